// ===== rtl/core/clock_run_compressor_top_macros.svh =====
`ifndef CLOCK_RUN_COMPRESSOR_TOP_MACROS_SVH
`define CLOCK_RUN_COMPRESSOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/crc_pkg.sv =====
`timescale 1ns / 1ps
package crc_pkg;

	localparam int DEF_TIME_BITS   = 48;
	localparam int VALUE_BITS      = 32;
	localparam int DEF_QUEUE_DEPTH = 4;
	localparam int COUNT_BITS      = 32;
	localparam int LIMIT_BITS      = 8;
	localparam int WIDTH_BITS      = 6;
	localparam int HIST_DEPTH      = 5;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 8;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE       = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH        = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOGGLE_LIMIT = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE_LIMIT = 2'd3;

	localparam logic OP_CHANGE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	localparam logic KIND_VALUE = 1'b0;
	localparam logic KIND_RUN   = 1'b1;

	localparam logic [1:0] LEVEL_LOW     = 2'd0;
	localparam logic [1:0] LEVEL_HIGH    = 2'd1;
	localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET         = 6'd1;
	localparam logic [LIMIT_BITS-1:0] TOGGLE_LIMIT_RESET  = 8'd4;
	localparam logic [LIMIT_BITS-1:0] STRIDE_LIMIT_RESET  = 8'd2;
	localparam logic [HIST_DEPTH-1:0] HIST_FULL           = 5'h1f;

	typedef struct packed {
		logic has_run;
		logic has_val;
	} rec_flags_t;

endpackage

// ===== rtl/core/crc_front.sv =====
`timescale 1ns / 1ps
module crc_front #(
	parameter int TIME_BITS = crc_pkg::DEF_TIME_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [crc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [crc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               accept,
	input  logic                               op,
	input  logic [TIME_BITS-1:0]               stamp,
	input  logic [crc_pkg::VALUE_BITS-1:0]     sample,
	output logic                               push,
	output crc_pkg::rec_flags_t                flags,
	output logic [TIME_BITS-1:0]               rec_period,
	output logic [crc_pkg::VALUE_BITS-1:0]     rec_value,
	output logic [crc_pkg::COUNT_BITS-1:0]     rec_repeats
);
	import crc_pkg::*;

	logic                  enable_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic [LIMIT_BITS-1:0] tlim_q;
	logic [LIMIT_BITS-1:0] slim_q;

	logic [VALUE_BITS-1:0] hist_q [HIST_DEPTH];
	logic [HIST_DEPTH-1:0] vmask_q;
	logic [1:0]            level_q;
	logic                  av_q;
	logic [TIME_BITS-1:0]  at_q;
	logic [TIME_BITS-1:0]  rp_q;
	logic [COUNT_BITS-1:0] rc_q;

	logic                  stride, tog;
	logic [VALUE_BITS-1:0] wm, v, d1, e1, d2, e2;
	logic [HIST_DEPTH-1:0] vmask_n;
	logic                  stride_match, tog_match;
	logic [TIME_BITS-1:0]  gap;
	logic [COUNT_BITS-1:0] lim, rc_inc;
	logic                  do_track, match, absorbed, emit, val;
	logic                  av_n;
	logic [TIME_BITS-1:0]  at_n, rp_n;
	logic [COUNT_BITS-1:0] rc_n;

	assign stride = (width_q >= 6'd2) && (width_q <= 6'd32);
	assign tog    = (width_q == 6'd1);
	assign wm     = (stride || tog) ? (32'hFFFF_FFFF >> (6'd32 - width_q)) : 32'hFFFF_FFFF;
	assign v      = sample & wm;

	assign d1 = (v - hist_q[1]) & wm;
	assign e1 = (hist_q[1] - hist_q[3]) & wm;
	assign d2 = (hist_q[0] - hist_q[2]) & wm;
	assign e2 = (hist_q[2] - hist_q[4]) & wm;

	assign vmask_n      = {vmask_q[HIST_DEPTH-2:0], 1'b1};
	assign stride_match = (vmask_n == HIST_FULL) && (d1 == e1) && (d2 == e2) && (d1 == d2);
	assign tog_match    = ((level_q == LEVEL_HIGH) && !v[0]) || ((level_q == LEVEL_LOW) && v[0]);

	assign gap    = stamp - at_q;
	assign rc_inc = (rc_q == '1) ? rc_q : rc_q + 1'b1;

	always_comb begin
		do_track = 1'b0;
		match    = 1'b0;
		absorbed = 1'b0;
		emit     = 1'b0;
		av_n     = av_q;
		at_n     = at_q;
		rp_n     = rp_q;
		rc_n     = rc_q;
		if (op == OP_FLUSH) begin
			lim = (width_q > 6'd1) ? COUNT_BITS'(slim_q) : COUNT_BITS'(tlim_q);
		end else if (stride) begin
			lim = COUNT_BITS'(slim_q);
		end else begin
			lim = COUNT_BITS'(tlim_q);
		end

		if (op == OP_FLUSH) begin
			if (enable_q && av_q && (rc_q > lim)) begin
				emit = 1'b1;
				av_n = 1'b0;
				rc_n = '0;
			end
		end else if (enable_q && stride) begin
			do_track = 1'b1;
			match    = stride_match;
		end else if (enable_q && tog) begin
			do_track = 1'b1;
			match    = tog_match;
		end

		if (do_track) begin
			if (match && !av_q) begin
				av_n = 1'b1;
				at_n = stamp;
				rc_n = '0;
			end else if (match && (rc_q == '0)) begin
				rp_n = gap;
				at_n = stamp;
				rc_n = COUNT_BITS'(1);
			end else if (match && (rp_q == gap)) begin
				rc_n     = rc_inc;
				at_n     = stamp;
				absorbed = (rc_inc > lim);
			end else if (rc_q > lim) begin
				// break a long run: report it, then restart
				emit = 1'b1;
				av_n = 1'b0;
				rc_n = '0;
			end else begin
				av_n = 1'b0;
			end
		end

		val = (op == OP_CHANGE) && !absorbed;
	end

	assign push          = accept && (emit || val);
	assign flags.has_run = emit;
	assign flags.has_val = val;
	assign rec_period    = rp_q;
	assign rec_value     = v;
	assign rec_repeats   = rc_q - lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			width_q  <= WIDTH_RESET;
			tlim_q   <= TOGGLE_LIMIT_RESET;
			slim_q   <= STRIDE_LIMIT_RESET;
			vmask_q  <= '0;
			level_q  <= LEVEL_UNKNOWN;
			av_q     <= 1'b0;
			at_q     <= '0;
			rp_q     <= '0;
			rc_q     <= '0;
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: begin
					enable_q <= cfg_data[0];
				end
				REG_WIDTH: begin
					width_q <= cfg_data[WIDTH_BITS-1:0];
					av_q    <= (cfg_data[WIDTH_BITS-1:0] != 6'd1);
				end
				REG_TOGGLE_LIMIT: begin
					tlim_q <= cfg_data;
				end
				REG_STRIDE_LIMIT: begin
					slim_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			av_q <= av_n;
			at_q <= at_n;
			rp_q <= rp_n;
			rc_q <= rc_n;
			if (op == OP_CHANGE && enable_q && stride) begin
				vmask_q   <= vmask_n;
				hist_q[0] <= v;
				for (int i = 1; i < HIST_DEPTH; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end
			if (op == OP_CHANGE && enable_q && !stride && tog) begin
				level_q <= {1'b0, v[0]};
			end
		end
	end

endmodule

// ===== rtl/core/crc_queue.sv =====
`timescale 1ns / 1ps
module crc_queue #(
	parameter int DATA_BITS = 64,
	parameter int DEPTH     = crc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic                 pop,
	output logic [DATA_BITS-1:0] rd_data,
	output logic                 full,
	output logic                 empty
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [DATA_BITS-1:0] mem_q [DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]  count_q;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/crc_back.sv =====
`timescale 1ns / 1ps
module crc_back #(
	parameter int TIME_BITS = crc_pkg::DEF_TIME_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  crc_pkg::rec_flags_t            head_flags,
	input  logic [TIME_BITS-1:0]           head_stamp,
	input  logic [TIME_BITS-1:0]           head_period,
	input  logic [crc_pkg::VALUE_BITS-1:0] head_value,
	input  logic [crc_pkg::COUNT_BITS-1:0] head_repeats,
	output logic                           pop,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic                           kind,
	output logic [TIME_BITS-1:0]           stamp_out,
	output logic [crc_pkg::VALUE_BITS-1:0] value_out,
	output logic [TIME_BITS-1:0]           period,
	output logic [crc_pkg::COUNT_BITS-1:0] repeats,
	output logic                           last
);
	import crc_pkg::*;

	logic                  valid_q, phase_q, kind_q, last_q;
	logic [TIME_BITS-1:0]  stamp_q, period_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [COUNT_BITS-1:0] repeats_q;
	logic                  load, run_word;

	assign load     = !valid_q || !out_stall;
	assign run_word = head_flags.has_run && !phase_q;
	// hold the entry after its run word when a value word still follows
	assign pop      = load && head_valid && !(run_word && head_flags.has_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				phase_q <= run_word && head_flags.has_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			stamp_q <= head_stamp;
			if (run_word) begin
				kind_q    <= KIND_RUN;
				value_q   <= '0;
				period_q  <= head_period;
				repeats_q <= head_repeats;
				last_q    <= !head_flags.has_val;
			end else begin
				kind_q    <= KIND_VALUE;
				value_q   <= head_value;
				period_q  <= '0;
				repeats_q <= '0;
				last_q    <= 1'b1;
			end
		end
	end

	assign out_valid = valid_q;
	assign kind      = kind_q;
	assign stamp_out = stamp_q;
	assign value_out = value_q;
	assign period    = period_q;
	assign repeats   = repeats_q;
	assign last      = last_q;

endmodule

// ===== rtl/core/clock_run_compressor_top.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Word
// in       | sink      | in_valid / in_stall  | op, stamp, sample
// out      | source    | out_valid/out_stall  | kind, stamp_out, value_out, period, repeats, last
// cfg      | sink      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An input word is classified and its state updated in the cycle it is taken; it reaches
// the output register through the result queue. One word enters per cycle while in_stall
// is low; the output register delivers one result per cycle while out_stall is low, so an
// input that yields a run record and a value record holds the output for both. The result
// queue (QUEUE_DEPTH entries) absorbs that and output stalls; in_stall is high only while
// it is full. Reset clears all tracking state and the queue; cfg_ready is always high.
module clock_run_compressor_top #(
	parameter int TIME_BITS   = crc_pkg::DEF_TIME_BITS,
	parameter int QUEUE_DEPTH = crc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [crc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [crc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               op,
	input  logic [TIME_BITS-1:0]               stamp,
	input  logic [crc_pkg::VALUE_BITS-1:0]     sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               kind,
	output logic [TIME_BITS-1:0]               stamp_out,
	output logic [crc_pkg::VALUE_BITS-1:0]     value_out,
	output logic [TIME_BITS-1:0]               period,
	output logic [crc_pkg::COUNT_BITS-1:0]     repeats,
	output logic                               last
);
	import crc_pkg::*;

	`include "clock_run_compressor_top_macros.svh"

	localparam int DATA_BITS = 2 + 2 * TIME_BITS + VALUE_BITS + COUNT_BITS;

	logic                  accept, q_push, q_pop, q_full, q_empty;
	rec_flags_t            f_flags, h_flags;
	logic [TIME_BITS-1:0]  f_period, h_stamp, h_period;
	logic [VALUE_BITS-1:0] f_value, h_value;
	logic [COUNT_BITS-1:0] f_repeats, h_repeats;
	logic [DATA_BITS-1:0]  q_wr, q_rd;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;

	crc_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.op          (op),
		.stamp       (stamp),
		.sample      (sample),
		.push        (q_push),
		.flags       (f_flags),
		.rec_period  (f_period),
		.rec_value   (f_value),
		.rec_repeats (f_repeats)
	);

	assign q_wr = {f_flags, stamp, f_period, f_value, f_repeats};
	assign {h_flags, h_stamp, h_period, h_value, h_repeats} = q_rd;

	crc_queue #(
		.DATA_BITS(DATA_BITS),
		.DEPTH    (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	crc_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!q_empty),
		.head_flags   (h_flags),
		.head_stamp   (h_stamp),
		.head_period  (h_period),
		.head_value   (h_value),
		.head_repeats (h_repeats),
		.pop          (q_pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.kind         (kind),
		.stamp_out    (stamp_out),
		.value_out    (value_out),
		.period       (period),
		.repeats      (repeats),
		.last         (last)
	);

	`CRC_ASSERT_NOW(a_pop_nonempty, clk, arst_n, q_pop, !q_empty, "pop from empty queue")
	`CRC_ASSERT_NEXT(a_run_then_value, clk, arst_n, out_valid && !out_stall && kind == KIND_RUN && !last, out_valid && kind == KIND_VALUE && last, "run record not followed by value record")
	`CRC_ASSERT_NOW(a_run_fields, clk, arst_n, out_valid && kind == KIND_RUN, value_out == '0 && repeats != '0, "bad run record fields")
	`CRC_ASSERT_NOW(a_value_fields, clk, arst_n, out_valid && kind == KIND_VALUE, period == '0 && repeats == '0 && last, "bad value record fields")

endmodule

// ===== tb/run_record_checker.sv =====
`timescale 1ns / 1ps
module run_record_checker #(
	parameter int TW = crc_pkg::DEF_TIME_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [crc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [crc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               op,
	input  logic [TW-1:0]                      stamp,
	input  logic [crc_pkg::VALUE_BITS-1:0]     sample,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               kind,
	input  logic [TW-1:0]                      stamp_out,
	input  logic [crc_pkg::VALUE_BITS-1:0]     value_out,
	input  logic [TW-1:0]                      period,
	input  logic [crc_pkg::COUNT_BITS-1:0]     repeats,
	input  logic                               last,
	output int                                 mismatches,
	output int                                 pending,
	output int                                 value_recs,
	output int                                 run_recs,
	output int                                 words_seen
);
	import crc_pkg::*;

	typedef struct packed {
		logic                  kind;
		logic [TW-1:0]         when_t;
		logic [VALUE_BITS-1:0] value;
		logic [TW-1:0]         per;
		logic [COUNT_BITS-1:0] reps;
		logic                  fin;
	} run_rec_t;

	// register copies
	logic                  cmp_on;
	logic [WIDTH_BITS-1:0] sig_width;
	logic [LIMIT_BITS-1:0] tog_limit;
	logic [LIMIT_BITS-1:0] str_limit;

	// tracking state
	logic [VALUE_BITS-1:0] hist [HIST_DEPTH];
	logic [HIST_DEPTH-1:0] hist_fill;
	logic [1:0]            last_bit;
	logic                  run_armed;
	logic [TW-1:0]         run_mark;
	logic [TW-1:0]         run_step;
	logic [COUNT_BITS-1:0] run_len;

	run_rec_t due_recs[$];
	run_rec_t step_recs[$];
	run_rec_t want;

	task automatic report_mismatch(input string what, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
	endtask

	task automatic close_run(input logic [TW-1:0] t, input logic [COUNT_BITS-1:0] lim);
		run_rec_t r;
		r = '0;
		r.kind = KIND_RUN;
		r.when_t = t;
		r.per = run_step;
		r.reps = run_len - lim;
		step_recs.push_back(r);
		run_armed = 1'b0;
		run_len = '0;
	endtask

	task automatic follow_run(input logic hit, input logic [TW-1:0] t,
			input logic [COUNT_BITS-1:0] lim, output logic took);
		logic [TW-1:0] gap;
		gap = t - run_mark;
		took = 1'b0;
		if (hit && !run_armed) begin
			run_armed = 1'b1;
			run_mark = t;
			run_len = '0;
		end else if (hit && run_len == 0) begin
			run_step = gap;
			run_mark = t;
			run_len = 1;
		end else if (hit && run_step == gap) begin
			if (run_len != '1)
				run_len++;
			run_mark = t;
			took = run_len > lim;
		end else if (run_len > lim) begin
			close_run(t, lim);
		end else begin
			run_armed = 1'b0;
		end
	endtask

	task automatic compress_word(input logic opc, input logic [TW-1:0] t,
			input logic [VALUE_BITS-1:0] s);
		logic                  stride_mode;
		logic [VALUE_BITS-1:0] wm, v, d1, e1, d2, e2;
		logic [COUNT_BITS-1:0] lim;
		logic                  hit, took;
		run_rec_t              r;
		step_recs.delete();
		stride_mode = sig_width > 1 && sig_width <= 32;
		wm = (stride_mode || sig_width == 1) ? 32'hFFFF_FFFF >> (6'd32 - sig_width) : '1;
		v = s & wm;
		took = 1'b0;
		if (opc == OP_FLUSH) begin
			lim = (sig_width > 1) ? {24'd0, str_limit} : {24'd0, tog_limit};
			if (cmp_on && run_armed && run_len > lim)
				close_run(t, lim);
		end else begin
			if (cmp_on && stride_mode) begin
				d1 = (v - hist[1]) & wm;
				e1 = (hist[1] - hist[3]) & wm;
				d2 = (hist[0] - hist[2]) & wm;
				e2 = (hist[2] - hist[4]) & wm;
				hist_fill = {hist_fill[HIST_DEPTH-2:0], 1'b1};
				hit = hist_fill == HIST_FULL && d1 == e1 && d2 == e2 && d1 == d2;
				follow_run(hit, t, {24'd0, str_limit}, took);
				for (int i = HIST_DEPTH - 1; i > 0; i--)
					hist[i] = hist[i-1];
				hist[0] = v;
			end else if (cmp_on && sig_width == 1) begin
				hit = (last_bit == LEVEL_HIGH && !v[0]) || (last_bit == LEVEL_LOW && v[0]);
				follow_run(hit, t, {24'd0, tog_limit}, took);
				last_bit = v[0] ? LEVEL_HIGH : LEVEL_LOW;
			end
			if (!took) begin
				r = '0;
				r.kind = KIND_VALUE;
				r.when_t = t;
				r.value = v;
				step_recs.push_back(r);
			end
		end
		if (step_recs.size() > 0)
			step_recs[step_recs.size()-1].fin = 1'b1;
		foreach (step_recs[i])
			due_recs.push_back(step_recs[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_on = 1'b0;
			sig_width = WIDTH_RESET;
			tog_limit = TOGGLE_LIMIT_RESET;
			str_limit = STRIDE_LIMIT_RESET;
			foreach (hist[i])
				hist[i] = '0;
			hist_fill = '0;
			last_bit = LEVEL_UNKNOWN;
			run_armed = 1'b0;
			run_mark = '0;
			run_step = '0;
			run_len = '0;
			due_recs.delete();
			mismatches = 0;
			value_recs = 0;
			run_recs = 0;
			words_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_recs.size() == 0) begin
					report_mismatch("record with nothing expected, stamp", 0, stamp_out);
				end else begin
					want = due_recs.pop_front();
					if (kind !== want.kind)
						report_mismatch("kind", want.kind, kind);
					if (stamp_out !== want.when_t)
						report_mismatch("stamp_out", want.when_t, stamp_out);
					if (value_out !== want.value)
						report_mismatch("value_out", want.value, value_out);
					if (period !== want.per)
						report_mismatch("period", want.per, period);
					if (repeats !== want.reps)
						report_mismatch("repeats", want.reps, repeats);
					if (last !== want.fin)
						report_mismatch("last", want.fin, last);
					if (want.kind == KIND_RUN)
						run_recs++;
					else
						value_recs++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ENABLE: begin
						cmp_on = cfg_data[0];
					end
					REG_WIDTH: begin
						sig_width = cfg_data[WIDTH_BITS-1:0];
						run_armed = cfg_data[WIDTH_BITS-1:0] != 6'd1;
					end
					REG_TOGGLE_LIMIT: begin
						tog_limit = cfg_data[LIMIT_BITS-1:0];
					end
					REG_STRIDE_LIMIT: begin
						str_limit = cfg_data[LIMIT_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				compress_word(op, stamp, sample);
				words_seen++;
			end
		end
		pending = due_recs.size();
	end

endmodule

// ===== tb/tb_clock_run_compressor_top.sv =====
`timescale 1ns / 1ps
module tb_clock_run_compressor_top;
	import crc_pkg::*;

	localparam int TW           = DEF_TIME_BITS;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 450;
	localparam int PHASE_WORDS  = 75;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic                      op;
	logic [TW-1:0]             stamp;
	logic [VALUE_BITS-1:0]     sample;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      kind;
	logic [TW-1:0]             stamp_out;
	logic [VALUE_BITS-1:0]     value_out;
	logic [TW-1:0]             period;
	logic [COUNT_BITS-1:0]     repeats;
	logic                      last;

	int mismatches, pending, value_recs, run_recs, words_seen;

	int              send_idle_pct = 0;
	int              stall_pct = 0;
	logic            hold_off = 1'b0;
	logic            hold_req = 1'b0;
	int              cycles = 0;
	int              reg_writes = 0;
	int              words_sent = 0;
	int              phase, phase_start, k;
	logic [TW-1:0]   now;
	logic [5:0]      cur_width;

	always #6 clk = ~clk;

	clock_run_compressor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.stamp     (stamp),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.stamp_out (stamp_out),
		.value_out (value_out),
		.period    (period),
		.repeats   (repeats),
		.last      (last)
	);

	run_record_checker #(.TW(TW)) records (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.stamp      (stamp),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.stamp_out  (stamp_out),
		.value_out  (value_out),
		.period     (period),
		.repeats    (repeats),
		.last       (last),
		.mismatches (mismatches),
		.pending    (pending),
		.value_recs (value_recs),
		.run_recs   (run_recs),
		.words_seen (words_seen)
	);

	always @(negedge clk) begin
		out_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// long receiver hold-off: the result queue fills and in_stall rises
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (120) @(posedge clk);
		hold_off = 1'b0;
	end

	task automatic send_word(input logic opc, input logic [TW-1:0] t,
			input logic [VALUE_BITS-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= opc;
		stamp <= t;
		sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic step_change(input logic [TW-1:0] dt, input logic [VALUE_BITS-1:0] s);
		now += dt;
		send_word(OP_CHANGE, now, s);
	endtask

	task automatic flush_trace();
		send_word(OP_FLUSH, now, $urandom());
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
		if (idx == REG_WIDTH)
			cur_width = data[5:0];
		reg_writes++;
	endtask

	// drop valid, wait for every expected record, then let a no-result flush clear
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [VALUE_BITS-1:0] width_mask();
		return (cur_width >= 1 && cur_width <= 32) ? 32'hFFFF_FFFF >> (6'd32 - cur_width) : '1;
	endfunction

	function automatic logic [TW-1:0] pick_step();
		case ($urandom_range(9))
			0: return '0;
			7, 8: return TW'($urandom_range(5000, 51));
			9: return {16'd0, $urandom()};
			default: return TW'($urandom_range(50, 1));
		endcase
	endfunction

	function automatic logic [LIMIT_BITS-1:0] pick_limit();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'd4;
			4: return 8'd255;
			default: return LIMIT_BITS'($urandom_range(6));
		endcase
	endfunction

	task automatic toggle_burst(input int n, input logic [TW-1:0] per, input bit flaw);
		logic          lvl;
		logic [TW-1:0] gap;
		int            j, bad;
		lvl = 1'($urandom_range(1));
		bad = flaw ? int'($urandom_range(n - 1)) : -1;
		for (j = 0; j < n; j++) begin
			gap = per;
			if (j == bad) begin
				if ($urandom_range(1))
					lvl = ~lvl;
				else
					gap = per + 1;
			end
			step_change(gap, ($urandom() & 32'hFFFF_FFFE) | lvl);
			lvl = ~lvl;
		end
	endtask

	// two interleaved progressions with a common stride
	task automatic stride_burst(input int n, input logic [TW-1:0] per, input bit flaw);
		logic [VALUE_BITS-1:0] a, b, d, wm, val;
		logic [TW-1:0]         gap;
		int                    j, bad;
		wm = width_mask();
		a = $urandom();
		b = $urandom_range(1) ? a : $urandom();
		d = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(4);
		bad = flaw ? int'($urandom_range(n - 1)) : -1;
		for (j = 0; j < n; j++) begin
			gap = per;
			val = ((j % 2) ? b : a) + d * (j / 2);
			if (j == bad) begin
				if ($urandom_range(1))
					val = val + 1;
				else
					gap = per + 1;
			end
			step_change(gap, (val & wm) | ($urandom() & ~wm));
		end
	endtask

	task automatic noise_burst(input int n);
		int j;
		for (j = 0; j < n; j++)
			step_change(pick_step(), $urandom_range(1) ? $urandom() : $urandom_range(3));
	endtask

	task automatic pick_settings();
		logic [5:0] w;
		case ($urandom_range(11))
			0: w = 6'd0;
			1, 2, 3: w = 6'd1;
			4: w = 6'd2;
			5: w = 6'd3;
			6: w = 6'd8;
			7: w = 6'd31;
			8: w = 6'd32;
			9: w = 6'd33;
			10: w = 6'd63;
			default: w = 6'($urandom_range(63));
		endcase
		write_reg(REG_ENABLE, ($urandom_range(9) != 0) ? 8'd1 : 8'd0);
		// keep the width now and then so a run can span the phase boundary
		if ($urandom_range(2) != 0)
			write_reg(REG_WIDTH, {2'b00, w});
		write_reg(REG_TOGGLE_LIMIT, pick_limit());
		write_reg(REG_STRIDE_LIMIT, pick_limit());
	endtask

	task automatic random_burst();
		int            n, r;
		logic [TW-1:0] per;
		n = $urandom_range(24, 3);
		r = $urandom_range(19);
		per = pick_step();
		if (r >= 16 || cur_width == 0 || cur_width > 32)
			noise_burst(n);
		else if (cur_width == 1)
			toggle_burst(n, per, r >= 12);
		else
			stride_burst(n, per, r >= 12);
		if ($urandom_range(1))
			flush_trace();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_CHANGE;
		stamp = '0;
		sample = '0;
		now = '0;
		cur_width = WIDTH_RESET;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// compression off: plain value records, flush gives nothing
		step_change(5, 32'hFFFF_FFFF);
		step_change(5, 32'h0000_0000);
		flush_trace();
		settle();
		write_reg(REG_ENABLE, 8'd1);
		write_reg(REG_TOGGLE_LIMIT, 8'd0);
		for (k = 0; k < 6; k++)
			step_change(10, k % 2);
		// repeated level breaks the run: run record then value record
		step_change(10, 1);
		flush_trace();
		settle();
		write_reg(REG_WIDTH, 8'd32);
		write_reg(REG_STRIDE_LIMIT, 8'd0);
		for (k = 0; k < 8; k++)
			step_change(4, 32'hFFFF_FFF0 + 3 * k);
		flush_trace();
		settle();
		write_reg(REG_WIDTH, 8'd0);
		step_change(0, 32'hA5A5_5A5A);
		step_change(1, 32'h5A5A_A5A5);
		flush_trace();

		phase_start = words_sent;
		for (phase = 0; words_sent < phase_start + RANDOM_WORDS; phase++) begin
			settle();
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 52;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 52;
				end
				default: begin
					send_idle_pct = 29;
					stall_pct = 29;
				end
			endcase
			pick_settings();
			if (phase == 4)
				hold_req = 1'b1;
			k = words_sent;
			while (words_sent - k < PHASE_WORDS)
				random_burst();
		end

		// a toggle run long enough to pass the highest pack limit
		settle();
		write_reg(REG_ENABLE, 8'd1);
		write_reg(REG_WIDTH, 8'd1);
		write_reg(REG_TOGGLE_LIMIT, 8'd255);
		toggle_burst(262, 7, 0);
		flush_trace();

		// top of the time range, huge period included
		settle();
		write_reg(REG_TOGGLE_LIMIT, 8'd1);
		now = 48'h7FFF_FFFF_FF00;
		toggle_burst(8, 48'h40, 0);
		toggle_burst(6, 48'h1000_0000_0000, 0);
		flush_trace();
		now = 48'hFFFF_FFFF_FE00;
		toggle_burst(8, 48'h20, 0);
		step_change(48'hFF, $urandom());
		flush_trace();

		settle();
		repeat (12) @(negedge clk);
		$display("covered %0d input words and %0d register writes over %0d random phases",
			words_seen, reg_writes, phase);
		$display("checked %0d value records and %0d clock run records", value_recs, run_recs);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
